>>> rtl/dtri_pkg.sv
// ----------------------------------------------------------------------------
// Decimal text to rounded int16: shared package
// Scanner phase codes, the scanner state record and the character and
// clamp constants used by the scanner step and the top level.
// ----------------------------------------------------------------------------
package dtri_pkg;

  // Scanner phases of one token.
  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_SIGNED = 3'd1,
    PH_INT    = 3'd2,
    PH_FRAC   = 3'd3,
    PH_DONE   = 3'd4,
    PH_BAD    = 3'd5
  } scan_phase_t;

  localparam int unsigned AccWidth = 17;
  localparam int unsigned ResWidth = 16;

  // Accumulated state of the token seen so far.
  typedef struct packed {
    scan_phase_t         phase;
    logic                negative;
    logic [AccWidth-1:0] magnitude;
    logic                add_one;
    logic                digit_seen;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    phase:      PH_LEAD,
    negative:   1'b0,
    magnitude:  '0,
    add_one:    1'b0,
    digit_seen: 1'b0
  };

  // Character codes.
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_POINT = 8'd46;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_FIVE  = 8'd53;
  localparam logic [7:0] CH_NINE  = 8'd57;

  // Saturation and clamp limits.
  localparam logic [AccWidth-1:0] ACC_MAX     = '1;
  localparam logic [AccWidth:0]   POS_MAG_MAX = 18'd32767;
  localparam logic [AccWidth:0]   NEG_MAG_MAX = 18'd32768;

endpackage

>>> rtl/decimal_text_to_rounded_int16_unit.sv
// ----------------------------------------------------------------------------
// Decimal text to rounded int16 unit
// Streaming parser that turns a decimal number token into a rounded,
// clamped 16-bit signed integer.
// ----------------------------------------------------------------------------
// The block takes one byte of a token per transaction, with tlast on the
// final byte, and sustains one byte per clock cycle. Each byte is first
// captured in an input register; as it leaves it, the scanner state
// (phase, sign, 17-bit saturating accumulator with its multiply-by-ten add,
// rounding and digit flags) is updated, and a final byte loads the result
// register, which offers the result. Leading blanks are skipped, a sign and
// one point are accepted, the first fraction digit rounds halves away from
// zero, trailing text is ignored, and a malformed or digitless token gives
// 0. The input stalls only while a result waits and a further final byte
// is ready to replace it.
module decimal_text_to_rounded_int16_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tlast,   // final_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [15:0] rounded_value
);

  logic                  in_valid;
  logic [7:0]            in_byte;
  logic                  in_last;
  logic                  advance;
  dtri_pkg::scan_state_t scan;
  dtri_pkg::scan_state_t scan_next;
  logic [15:0]           result_next;
  logic                  out_valid;
  logic [15:0]           out_data;

  // A byte leaves the input register unless it is final and the result
  // register is still occupied.
  assign advance       = in_valid && (!in_last || !out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  // Scanner step.
  dtri_step u_step (
    .cur          (scan),
    .text_byte    (in_byte),
    .final_byte   (in_last),
    .nxt          (scan_next),
    .rounded_value(result_next)
  );

  // Scanner state.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan <= dtri_pkg::SCAN_RESET;
    end else if (advance) begin
      scan <= scan_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_last) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      out_data <= result_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // A final byte always leaves the scanner at its start.
  assert property (@(posedge clk) disable iff (rst)
    advance && in_last |=> scan == dtri_pkg::SCAN_RESET)
    else $error("scanner not restarted after final byte");

  // A result appears only after a final byte has been processed.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(advance && in_last))
    else $error("result raised without a final byte");

  // A held byte in the input register is not overwritten.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_byte) && $stable(in_last))
    else $error("held input byte lost");

  // No digit seen means nothing accumulated and no rounding.
  assert property (@(posedge clk) disable iff (rst)
    !scan.digit_seen |-> (scan.magnitude == '0) && !scan.add_one)
    else $error("accumulator set without a digit");

endmodule

>>> rtl/dtri_step.sv
// ----------------------------------------------------------------------------
// Decimal text to rounded int16: scanner step
// Combinational update of the scanner state for one byte, together with
// the rounded and clamped result that the token gives if the byte is final.
// ----------------------------------------------------------------------------
module dtri_step (
  input  dtri_pkg::scan_state_t cur,
  input  logic [7:0]            text_byte,
  input  logic                  final_byte,
  output dtri_pkg::scan_state_t nxt,
  output logic [15:0]           rounded_value
);

  logic                           is_blank;
  logic                           is_numeral;
  logic [3:0]                     digit_val;
  logic [20:0]                    acc_times_ten;
  logic [dtri_pkg::AccWidth-1:0]  acc_digit;
  dtri_pkg::scan_state_t          absorbed;
  logic [dtri_pkg::AccWidth:0]    mag_round;
  logic [dtri_pkg::AccWidth:0]    mag_clamp;
  logic                           no_value;

  // Character classes.
  assign is_blank = (text_byte == dtri_pkg::CH_SPACE) || (text_byte == dtri_pkg::CH_TAB) ||
                    (text_byte == dtri_pkg::CH_LF) || (text_byte == dtri_pkg::CH_CR);
  assign is_numeral = (text_byte >= dtri_pkg::CH_ZERO) && (text_byte <= dtri_pkg::CH_NINE);
  assign digit_val = 4'(text_byte - dtri_pkg::CH_ZERO);

  // Multiply by ten as two shifted copies, add the digit and saturate.
  assign acc_times_ten = {1'b0, cur.magnitude, 3'b000} + {3'b000, cur.magnitude, 1'b0}
                         + {17'd0, digit_val};
  assign acc_digit = (acc_times_ten > {4'd0, dtri_pkg::ACC_MAX}) ? dtri_pkg::ACC_MAX
                                                                 : acc_times_ten[16:0];

  // Phase transitions for one byte.
  always_comb begin
    absorbed = cur;
    unique case (cur.phase)
      dtri_pkg::PH_LEAD: begin
        if (is_blank) begin
          absorbed.phase = dtri_pkg::PH_LEAD;
        end else if (text_byte == dtri_pkg::CH_MINUS) begin
          absorbed.negative = 1'b1;
          absorbed.phase    = dtri_pkg::PH_SIGNED;
        end else if (text_byte == dtri_pkg::CH_PLUS) begin
          absorbed.phase = dtri_pkg::PH_SIGNED;
        end else if (is_numeral) begin
          absorbed.magnitude  = acc_digit;
          absorbed.digit_seen = 1'b1;
          absorbed.phase      = dtri_pkg::PH_INT;
        end else if (text_byte == dtri_pkg::CH_POINT) begin
          absorbed.phase = dtri_pkg::PH_FRAC;
        end else begin
          absorbed.phase = dtri_pkg::PH_BAD;
        end
      end
      dtri_pkg::PH_SIGNED: begin
        if (is_numeral) begin
          absorbed.magnitude  = acc_digit;
          absorbed.digit_seen = 1'b1;
          absorbed.phase      = dtri_pkg::PH_INT;
        end else if (text_byte == dtri_pkg::CH_POINT) begin
          absorbed.phase = dtri_pkg::PH_FRAC;
        end else begin
          absorbed.phase = dtri_pkg::PH_BAD;
        end
      end
      dtri_pkg::PH_INT: begin
        if (is_numeral) begin
          absorbed.magnitude  = acc_digit;
          absorbed.digit_seen = 1'b1;
        end else if (text_byte == dtri_pkg::CH_POINT) begin
          absorbed.phase = dtri_pkg::PH_FRAC;
        end else begin
          absorbed.phase = dtri_pkg::PH_DONE;
        end
      end
      dtri_pkg::PH_FRAC: begin
        // Only the first fraction digit decides the rounding.
        if (is_numeral) begin
          absorbed.digit_seen = 1'b1;
          if (text_byte >= dtri_pkg::CH_FIVE) begin
            absorbed.add_one = 1'b1;
          end
        end
        absorbed.phase = dtri_pkg::PH_DONE;
      end
      dtri_pkg::PH_DONE: begin
        absorbed.phase = dtri_pkg::PH_DONE;
      end
      default: begin
        absorbed.phase = dtri_pkg::PH_BAD;
      end
    endcase
  end

  // Rounding, clamping and sign of the result.
  assign mag_round = {1'b0, absorbed.magnitude} + {17'd0, absorbed.add_one};
  assign no_value  = (absorbed.phase == dtri_pkg::PH_BAD) ||
                     (absorbed.phase == dtri_pkg::PH_LEAD) || !absorbed.digit_seen;

  always_comb begin
    if (absorbed.negative) begin
      mag_clamp = (mag_round > dtri_pkg::NEG_MAG_MAX) ? dtri_pkg::NEG_MAG_MAX : mag_round;
    end else begin
      mag_clamp = (mag_round > dtri_pkg::POS_MAG_MAX) ? dtri_pkg::POS_MAG_MAX : mag_round;
    end
  end

  always_comb begin
    if (no_value) begin
      rounded_value = '0;
    end else if (absorbed.negative) begin
      rounded_value = 16'(~mag_clamp[15:0] + 16'd1);
    end else begin
      rounded_value = mag_clamp[15:0];
    end
  end

  // The final byte returns the scanner to its start.
  assign nxt = final_byte ? dtri_pkg::SCAN_RESET : absorbed;

endmodule
